@@ src/beacon_range_tracking_table_top_macros.svh @@
// assertion macros shared by the beacon range tracking table rtl
`ifndef BEACON_RANGE_TRACKING_TABLE_TOP_MACROS_SVH
`define BEACON_RANGE_TRACKING_TABLE_TOP_MACROS_SVH
`ifndef SYNTH
`define BRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same cycle check failed");
`define BRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next cycle check failed");
`else
`define BRT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BRT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/brt_pkg.sv @@
// shared types, constants and distance table of the beacon range tracking table
package brt_pkg;

   localparam int MAX_ENTRIES_DEF   = 32;
   localparam int HISTORY_DEPTH_DEF = 8;

   localparam int DIST_W   = 24;
   localparam int SLOT_W   = 5;
   localparam int ACTIVE_W = 6;
   localparam int STATUS_W = 3;

   localparam logic [63:0] PREFIX_HEAD  = 64'h0201_041A_FF4C_0002;
   localparam logic [7:0]  PREFIX_BYTE8 = 8'h15;
   localparam logic [7:0]  DEFAULT_TX_RESET = 8'hC4;
   localparam logic [DIST_W-1:0] DIST_MAX = 24'hFF_FFFF;

   localparam logic ACT_REGISTER = 1'b0;
   localparam logic ACT_SCAN     = 1'b1;

   localparam logic REG_DEFAULT_TX = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      ST_OBSERVED   = 3'd0,
      ST_REGISTERED = 3'd1,
      ST_PRESENT    = 3'd2,
      ST_NOT_BEACON = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef struct packed {
      logic capture;
      logic walk;
      logic decide;
      logic meta_read;
      logic load_avg;
      logic sample;
      logic sum;
      logic div_start;
      logic finish;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      logic is_scan;
      logic beacon_ok;
      logic hit;
      logic free_found;
      logic walk_done;
      logic sum_done;
      logic div_done;
   } dp_status_type;

   // distance table covers tx - rssi from -80 to 96 db
   localparam int RANGE_POINTS = 177;
   localparam int RANGE_MIN_DB = -80;
   localparam int RANGE_MAX_DB = 96;

   typedef logic [DIST_W-1:0] range_lut_type [RANGE_POINTS];

   function automatic logic [63:0] tenth_db_root(input int r);
      case (r)
         0: return 64'd1000000000;
         1: return 64'd1122018454;
         2: return 64'd1258925412;
         3: return 64'd1412537545;
         4: return 64'd1584893192;
         5: return 64'd1778279410;
         6: return 64'd1995262315;
         7: return 64'd2238721139;
         8: return 64'd2511886432;
         9: return 64'd2818382931;
         10: return 64'd3162277660;
         11: return 64'd3548133892;
         12: return 64'd3981071706;
         13: return 64'd4466835922;
         14: return 64'd5011872336;
         15: return 64'd5623413252;
         16: return 64'd6309573445;
         17: return 64'd7079457844;
         18: return 64'd7943282347;
         default: return 64'd8912509381;
      endcase
   endfunction

   function automatic range_lut_type build_range_lut();
      range_lut_type lut;
      int i;
      int j;
      int e;
      int k;
      int r;
      int q;
      logic [63:0] num;
      logic [63:0] val;
      for (i = 0; i < RANGE_POINTS; i++) begin
         e = i + RANGE_MIN_DB + 100;
         k = e / 20;
         r = e % 20;
         q = k - 5;
         num = tenth_db_root(r) * 64'd256;
         if (q >= 0) begin
            for (j = 0; j < q; j++) begin
               num = num * 64'd10;
            end
            val = (num + 64'd500000000) / 64'd1000000000;
         end else begin
            case (q)
               -1: val = (num + 64'd5000000000) / 64'd10000000000;
               -2: val = (num + 64'd50000000000) / 64'd100000000000;
               -3: val = (num + 64'd500000000000) / 64'd1000000000000;
               default: val = (num + 64'd5000000000000) / 64'd10000000000000;
            endcase
         end
         lut[i] = (val > 64'(DIST_MAX)) ? DIST_MAX : val[DIST_W-1:0];
      end
      return lut;
   endfunction

   localparam range_lut_type RANGE_LUT = build_range_lut();

endpackage

@@ src/brt_div.sv @@
// restoring divider, one quotient bit per cycle
module brt_div #(
   parameter int NW = 28,
   parameter int DW = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [NW-1:0] quotient,
   output logic          done
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] quo_ff;
   logic [NW-1:0] quo_in;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] rem_in;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   trial;

   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = DW'(trial - {1'b0, den_ff});
         quo_in = {quo_ff[NW-2:0], 1'b1};
      end else begin
         rem_in = trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

@@ src/brt_dpath.sv @@
// table memories, lookup walk, sample history and averaging datapath
module brt_dpath #(
   parameter int MAX_ENTRIES   = brt_pkg::MAX_ENTRIES_DEF,
   parameter int HISTORY_DEPTH = brt_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  brt_pkg::dp_cmd_type    cmd,
   output brt_pkg::dp_status_type sts,
   input  logic                   item_action,
   input  logic [47:0]            item_address,
   input  logic [7:0]             item_tx_power,
   input  logic [7:0]             item_rssi,
   input  logic [63:0]            item_adv_head,
   input  logic [7:0]             item_adv_byte8,
   input  logic [7:0]             default_tx,
   output logic [brt_pkg::STATUS_W-1:0] out_status,
   output logic [brt_pkg::SLOT_W-1:0]   out_slot,
   output logic [brt_pkg::DIST_W-1:0]   out_distance,
   output logic [brt_pkg::DIST_W-1:0]   out_average,
   output logic [brt_pkg::ACTIVE_W-1:0] out_active
);
   import brt_pkg::*;

   localparam int IDXW = $clog2(MAX_ENTRIES);
   localparam int CNTW = $clog2(MAX_ENTRIES + 1);
   localparam int HW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW   = $clog2(HISTORY_DEPTH + 1);
   localparam int RAW  = $clog2(MAX_ENTRIES * HISTORY_DEPTH);
   localparam int SUMW = DIST_W + FW;

   // captured item
   logic              scan_ff;
   logic [47:0]       addr_ff;
   logic [7:0]        tx_ff;
   logic [7:0]        rssi_ff;
   logic              beacon_ff;

   // flop state
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [MAX_ENTRIES-1:0] active_ff;
   logic [CNTW-1:0]        active_cnt_ff;

   // memories
   logic [47:0]       addr_mem [MAX_ENTRIES];
   logic [7:0]        tx_mem   [MAX_ENTRIES];
   logic [HW-1:0]     widx_mem [MAX_ENTRIES];
   logic [FW-1:0]     fill_mem [MAX_ENTRIES];
   logic [DIST_W-1:0] avg_mem  [MAX_ENTRIES];
   logic [DIST_W-1:0] ring_mem [MAX_ENTRIES * HISTORY_DEPTH];

   // walk
   logic [IDXW:0]     walk_idx_ff;
   logic [47:0]       addr_rd_ff;
   logic              rdv_ff;
   logic [IDXW-1:0]   rd_idx_ff;
   logic              rd_pend_ff;
   logic              hit_ff;
   logic [IDXW-1:0]   hit_idx_ff;
   logic              free_ff;
   logic [IDXW-1:0]   free_idx_ff;

   // entry work
   logic [IDXW-1:0]   slot_ff;
   logic [7:0]        tx_rd_ff;
   logic [HW-1:0]     widx_rd_ff;
   logic [FW-1:0]     fill_rd_ff;
   logic [DIST_W-1:0] avg_rd_ff;
   logic [FW-1:0]     fill_new_ff;
   logic [RAW-1:0]    ring_base_ff;
   logic [FW-1:0]     sidx_ff;
   logic [DIST_W-1:0] ring_rd_ff;
   logic              spend_ff;
   logic              slast_ff;
   logic [SUMW-1:0]   sum_ff;

   // result
   status_type        res_status_ff;
   logic [IDXW-1:0]   res_slot_ff;
   logic [DIST_W-1:0] res_dist_ff;
   logic [DIST_W-1:0] res_avg_ff;

   logic              claim;
   logic [7:0]        claim_tx;
   logic signed [8:0] diff;
   logic [DIST_W-1:0] dist_sample;
   logic [HW-1:0]     widx_next;
   logic [FW-1:0]     fill_next;
   logic [RAW-1:0]    sample_base;
   logic [SUMW-1:0]   div_quo;
   logic              div_done;
   logic              new_active;

   assign claim    = cmd.decide && !hit_ff && free_ff && (!scan_ff || beacon_ff);
   assign claim_tx = scan_ff ? default_tx : tx_ff;

   assign diff = $signed({tx_rd_ff[7], tx_rd_ff}) - $signed({rssi_ff[7], rssi_ff});

   always_comb begin
      if (diff > 9'sd96) begin
         dist_sample = DIST_MAX;
      end else if (diff < -9'sd80) begin
         dist_sample = '0;
      end else begin
         dist_sample = RANGE_LUT[8'(diff + 9'sd80)];
      end
   end

   assign widx_next = (widx_rd_ff == HW'(HISTORY_DEPTH - 1)) ? '0 : HW'(widx_rd_ff + 1'b1);
   assign fill_next = (fill_rd_ff < FW'(HISTORY_DEPTH)) ? FW'(fill_rd_ff + 1'b1) : fill_rd_ff;
   assign sample_base = RAW'(slot_ff) * RAW'(HISTORY_DEPTH);
   assign new_active  = |div_quo[DIST_W-1:0];

   brt_div #(
      .NW (SUMW),
      .DW (FW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (fill_new_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         active_ff     <= '0;
         active_cnt_ff <= '0;
         rd_pend_ff    <= 1'b0;
         spend_ff      <= 1'b0;
         walk_idx_ff   <= '0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         if (cmd.capture) begin
            walk_idx_ff <= '0;
            hit_ff      <= 1'b0;
            free_ff     <= 1'b0;
            rd_pend_ff  <= 1'b0;
         end else if (cmd.walk && walk_idx_ff < (IDXW+1)'(MAX_ENTRIES)) begin
            walk_idx_ff <= walk_idx_ff + 1'b1;
            rd_pend_ff  <= 1'b1;
         end else begin
            rd_pend_ff <= 1'b0;
         end
         if (rd_pend_ff) begin
            if (rdv_ff && addr_rd_ff == addr_ff && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!rdv_ff && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
         if (claim) begin
            valid_ff[free_idx_ff]  <= 1'b1;
            active_ff[free_idx_ff] <= 1'b0;
         end
         spend_ff <= cmd.sum && (sidx_ff < fill_new_ff);
         if (cmd.finish) begin
            active_ff[slot_ff] <= new_active;
            if (new_active && !active_ff[slot_ff]) begin
               active_cnt_ff <= active_cnt_ff + 1'b1;
            end else if (!new_active && active_ff[slot_ff]) begin
               active_cnt_ff <= active_cnt_ff - 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         scan_ff   <= (item_action == ACT_SCAN);
         addr_ff   <= item_address;
         tx_ff     <= item_tx_power;
         rssi_ff   <= item_rssi;
         beacon_ff <= (item_adv_head == PREFIX_HEAD) && (item_adv_byte8 == PREFIX_BYTE8);
      end
      if (rd_pend_ff) begin
         if (rdv_ff && addr_rd_ff == addr_ff && !hit_ff) begin
            hit_idx_ff <= rd_idx_ff;
         end
         if (!rdv_ff && !free_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.walk) begin
         rdv_ff    <= valid_ff[walk_idx_ff[IDXW-1:0]];
         rd_idx_ff <= walk_idx_ff[IDXW-1:0];
      end
      if (cmd.decide) begin
         res_dist_ff <= '0;
         res_avg_ff  <= '0;
         slot_ff     <= hit_ff ? hit_idx_ff : free_idx_ff;
         res_slot_ff <= '0;
         if (!scan_ff) begin
            if (hit_ff) begin
               res_status_ff <= ST_PRESENT;
               res_slot_ff   <= hit_idx_ff;
            end else if (free_ff) begin
               res_status_ff <= ST_REGISTERED;
               res_slot_ff   <= free_idx_ff;
            end else begin
               res_status_ff <= ST_FULL;
            end
         end else if (!beacon_ff) begin
            res_status_ff <= ST_NOT_BEACON;
         end else if (hit_ff || free_ff) begin
            res_status_ff <= ST_OBSERVED;
            res_slot_ff   <= hit_ff ? hit_idx_ff : free_idx_ff;
         end else begin
            res_status_ff <= ST_FULL;
         end
      end
      if (cmd.load_avg) begin
         res_avg_ff <= avg_rd_ff;
      end
      if (cmd.sample) begin
         res_dist_ff  <= dist_sample;
         fill_new_ff  <= fill_next;
         ring_base_ff <= sample_base;
         sidx_ff      <= '0;
         sum_ff       <= '0;
      end
      if (cmd.sum && sidx_ff < fill_new_ff) begin
         sidx_ff  <= sidx_ff + 1'b1;
         slast_ff <= (sidx_ff == FW'(fill_new_ff - 1'b1));
      end
      if (spend_ff) begin
         sum_ff <= sum_ff + SUMW'(ring_rd_ff);
      end
      if (cmd.finish) begin
         res_avg_ff <= div_quo[DIST_W-1:0];
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         addr_rd_ff <= addr_mem[walk_idx_ff[IDXW-1:0]];
      end
      if (claim) begin
         addr_mem[free_idx_ff] <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.meta_read) begin
         tx_rd_ff <= tx_mem[slot_ff];
      end
      if (claim) begin
         tx_mem[free_idx_ff] <= claim_tx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.meta_read) begin
         widx_rd_ff <= widx_mem[slot_ff];
      end
      if (claim) begin
         widx_mem[free_idx_ff] <= '0;
      end else if (cmd.sample) begin
         widx_mem[slot_ff] <= widx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.meta_read) begin
         fill_rd_ff <= fill_mem[slot_ff];
      end
      if (claim) begin
         fill_mem[free_idx_ff] <= '0;
      end else if (cmd.sample) begin
         fill_mem[slot_ff] <= fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.meta_read) begin
         avg_rd_ff <= avg_mem[slot_ff];
      end
      if (claim) begin
         avg_mem[free_idx_ff] <= '0;
      end else if (cmd.finish) begin
         avg_mem[slot_ff] <= div_quo[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum && sidx_ff < fill_new_ff) begin
         ring_rd_ff <= ring_mem[RAW'(ring_base_ff + RAW'(sidx_ff))];
      end
      if (cmd.sample) begin
         ring_mem[RAW'(sample_base + RAW'(widx_rd_ff))] <= dist_sample;
      end
   end

   assign sts.is_scan    = scan_ff;
   assign sts.beacon_ok  = beacon_ff;
   assign sts.hit        = hit_ff;
   assign sts.free_found = free_ff;
   assign sts.walk_done  = rd_pend_ff && (rd_idx_ff == IDXW'(MAX_ENTRIES - 1));
   assign sts.sum_done   = spend_ff && slast_ff;
   assign sts.div_done   = div_done;

   assign out_status   = res_status_ff;
   assign out_slot     = SLOT_W'(res_slot_ff);
   assign out_distance = res_dist_ff;
   assign out_average  = res_avg_ff;
   assign out_active   = ACTIVE_W'(active_cnt_ff);
endmodule

@@ src/brt_ctrl.sv @@
// sequencing state machine of the beacon range tracking table
`include "beacon_range_tracking_table_top_macros.svh"
module brt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  brt_pkg::dp_status_type sts,
   output brt_pkg::dp_cmd_type    cmd
);
   import brt_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_WALK    = 10'b00_0000_0010,
      S_DECIDE  = 10'b00_0000_0100,
      S_META    = 10'b00_0000_1000,
      S_LOADAVG = 10'b00_0001_0000,
      S_SAMPLE  = 10'b00_0010_0000,
      S_SUM     = 10'b00_0100_0000,
      S_DIVGO   = 10'b00_1000_0000,
      S_DIV     = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.walk_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!sts.is_scan) begin
               state_in = sts.hit ? S_META : S_DONE;
            end else if (sts.beacon_ok && (sts.hit || sts.free_found)) begin
               state_in = S_META;
            end else begin
               state_in = S_DONE;
            end
         end
         S_META: state_in = sts.is_scan ? S_SAMPLE : S_LOADAVG;
         S_LOADAVG: state_in = S_DONE;
         S_SAMPLE: state_in = S_SUM;
         S_SUM: begin
            if (sts.sum_done) begin
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: state_in = S_DIV;
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign cmd.capture   = (state_ff == S_IDLE) && start;
   assign cmd.walk      = (state_ff == S_WALK);
   assign cmd.decide    = (state_ff == S_DECIDE);
   assign cmd.meta_read = (state_ff == S_META);
   assign cmd.load_avg  = (state_ff == S_LOADAVG);
   assign cmd.sample    = (state_ff == S_SAMPLE);
   assign cmd.sum       = (state_ff == S_SUM);
   assign cmd.div_start = (state_ff == S_DIVGO);
   assign cmd.finish    = (state_ff == S_DIV) && sts.div_done;
   assign cmd.respond   = (state_ff == S_DONE);

   `BRT_ASSERT_NXT(a_start_walk, clock, reset, start && !busy, state_ff == S_WALK)
   `BRT_ASSERT_NXT(a_done_idle, clock, reset, state_ff == S_DONE, state_ff == S_IDLE)
   `BRT_ASSERT_IMP(a_div_in_wait, clock, reset, sts.div_done, state_ff == S_DIV)
   `BRT_ASSERT_IMP(a_sum_in_sum, clock, reset, sts.sum_done, state_ff == S_SUM)
endmodule

@@ src/beacon_range_tracking_table_top.sv @@
// top level of the beacon range tracking table: csr port, controller and datapath
//
// keeps up to MAX_ENTRIES beacons keyed by 48-bit address. an item is taken when start
// is high while busy is low; busy then stays high until the result has been shown.
// every item gives exactly one result, shown for one cycle with rsp_strobe high; the
// receiver cannot stall it, so it must take it in that cycle. an item first walks the
// address table one entry a cycle, which settles hit and lowest free entry. a register
// item then goes straight to its result, or on a hit first reads the entry and its average.
// a scan item of a beacon reads the entry, writes the new distance into its history
// ring, sums the ring one sample a cycle and divides by the fill count with a one bit
// per cycle divider. busy drops for one idle cycle before the next item. the csr port
// holds the tx power given to beacons first seen in a scan, at byte address 0
module beacon_range_tracking_table_top #(
   parameter int MAX_ENTRIES   = brt_pkg::MAX_ENTRIES_DEF,
   parameter int HISTORY_DEPTH = brt_pkg::HISTORY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [47:0] req_address,
   input  logic [7:0]  req_tx_power,
   input  logic [7:0]  req_rssi,
   input  logic [63:0] req_adv_head,
   input  logic [7:0]  req_adv_byte8,
   // result channel
   output logic        rsp_strobe,
   output logic [brt_pkg::STATUS_W-1:0] rsp_status,
   output logic [brt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [brt_pkg::DIST_W-1:0]   rsp_distance,
   output logic [brt_pkg::DIST_W-1:0]   rsp_average_distance,
   output logic [brt_pkg::ACTIVE_W-1:0] rsp_active_count,
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import brt_pkg::*;

   logic [7:0]    default_tx_ff;
   logic          csr_write;
   dp_cmd_type    cmd;
   dp_status_type sts;

   // register index is the word address, low bits ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_tx_ff <= DEFAULT_TX_RESET;
      end else if (csr_write && csr_paddr[2] == REG_DEFAULT_TX) begin
         default_tx_ff <= csr_pwdata[7:0];
      end
   end

   // read back sign extended, other word reads as zero
   assign csr_prdata = (csr_paddr[2] == REG_DEFAULT_TX) ?
                       {{24{default_tx_ff[7]}}, default_tx_ff} : 32'd0;

   brt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   brt_dpath #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .item_action    (req_action),
      .item_address   (req_address),
      .item_tx_power  (req_tx_power),
      .item_rssi      (req_rssi),
      .item_adv_head  (req_adv_head),
      .item_adv_byte8 (req_adv_byte8),
      .default_tx     (default_tx_ff),
      .out_status     (rsp_status),
      .out_slot       (rsp_slot),
      .out_distance   (rsp_distance),
      .out_average    (rsp_average_distance),
      .out_active     (rsp_active_count)
   );

   // result shown in the single done cycle
   assign rsp_strobe = cmd.respond;
endmodule

@@ sim/beacon_range_tracking_table_checker.sv @@
// result checker for the beacon range tracking table: predicts each result and compares it
module beacon_range_tracking_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_action,
   input  logic [47:0] req_address,
   input  logic [7:0]  req_tx_power,
   input  logic [7:0]  req_rssi,
   input  logic [63:0] req_adv_head,
   input  logic [7:0]  req_adv_byte8,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_status,
   input  logic [4:0]  rsp_slot,
   input  logic [23:0] rsp_distance,
   input  logic [23:0] rsp_average_distance,
   input  logic [5:0]  rsp_active_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          outstanding
);
   import brt_pkg::*;

   localparam int SLOTS = 32;
   localparam int DEPTH = 8;

   typedef struct {
      status_type  status;
      logic [4:0]  slot;
      logic [23:0] dist_q8;
      logic [23:0] avg;
      logic [5:0]  active;
   } outcome_type;

   // 10^(r/20) scaled by 1e9
   localparam longint unsigned ROOT_PPB [20] = '{
      64'd1000000000, 64'd1122018454, 64'd1258925412, 64'd1412537545,
      64'd1584893192, 64'd1778279410, 64'd1995262315, 64'd2238721139,
      64'd2511886432, 64'd2818382931, 64'd3162277660, 64'd3548133892,
      64'd3981071706, 64'd4466835922, 64'd5011872336, 64'd5623413252,
      64'd6309573445, 64'd7079457844, 64'd7943282347, 64'd8912509381};

   logic              tbl_valid [SLOTS];
   logic [47:0]       tbl_addr [SLOTS];
   logic signed [7:0] tbl_tx [SLOTS];
   logic [23:0]       tbl_ring [SLOTS][DEPTH];
   int                tbl_widx [SLOTS];
   int                tbl_fill [SLOTS];
   logic [23:0]       tbl_avg [SLOTS];
   logic signed [7:0] first_seen_tx;
   outcome_type       awaited [$];

   assign outstanding = awaited.size();

   function automatic logic [23:0] meters_q8(input int d);
      longint unsigned num, den, val;
      int e, q, r;
      if (d > 96) return DIST_MAX;
      if (d < -80) return 24'd0;
      e = d + 100;
      q = e / 20 - 5;
      r = e % 20;
      num = ROOT_PPB[r] * 256;
      den = 64'd1000000000;
      if (q >= 0) begin
         for (int i = 0; i < q; i++) num = num * 10;
      end else begin
         for (int i = 0; i < -q; i++) den = den * 10;
      end
      val = (num + den / 2) / den;
      return (val > 64'(DIST_MAX)) ? DIST_MAX : val[23:0];
   endfunction

   function automatic int lookup(input logic [47:0] a);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_addr[i] == a) return i;
      return -1;
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < SLOTS; i++)
         if (!tbl_valid[i]) return i;
      return -1;
   endfunction

   function automatic void claim(input int s, input logic [47:0] a, input logic [7:0] tx);
      tbl_valid[s] = 1'b1;
      tbl_addr[s] = a;
      tbl_tx[s] = tx;
      tbl_widx[s] = 0;
      tbl_fill[s] = 0;
      tbl_avg[s] = '0;
   endfunction

   function automatic outcome_type predict_sighting();
      outcome_type o;
      int s;
      longint unsigned total;
      s = lookup(req_address);
      o.dist_q8 = '0;
      o.avg = '0;
      if (req_action == ACT_REGISTER) begin
         if (s >= 0) begin
            o.status = ST_PRESENT;
            o.avg = tbl_avg[s];
         end else begin
            s = lowest_free();
            if (s >= 0) begin
               claim(s, req_address, req_tx_power);
               o.status = ST_REGISTERED;
            end else o.status = ST_FULL;
         end
      end else if (req_adv_head != PREFIX_HEAD || req_adv_byte8 != PREFIX_BYTE8) begin
         o.status = ST_NOT_BEACON;
         s = -1;
      end else begin
         if (s < 0) begin
            s = lowest_free();
            if (s >= 0) claim(s, req_address, first_seen_tx);
         end
         if (s < 0) o.status = ST_FULL;
         else begin
            o.status = ST_OBSERVED;
            o.dist_q8 = meters_q8(int'(tbl_tx[s]) - int'($signed(req_rssi)));
            tbl_ring[s][tbl_widx[s]] = o.dist_q8;
            tbl_widx[s] = (tbl_widx[s] + 1) % DEPTH;
            if (tbl_fill[s] < DEPTH) tbl_fill[s]++;
            total = 0;
            for (int i = 0; i < tbl_fill[s]; i++) total += tbl_ring[s][i];
            o.avg = 24'(total / tbl_fill[s]);
            tbl_avg[s] = o.avg;
         end
      end
      o.slot = (s >= 0) ? 5'(s) : 5'd0;
      o.active = '0;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_avg[i] > 0) o.active++;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_tx[i] = '0;
            tbl_widx[i] = 0;
            tbl_fill[i] = 0;
            tbl_avg[i] = '0;
         end
         first_seen_tx = DEFAULT_TX_RESET;
         awaited.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result status %0d", rsp_status);
            end else begin
               want = awaited.pop_front();
               if (rsp_status !== want.status || rsp_slot !== want.slot ||
                   rsp_distance !== want.dist_q8 || rsp_average_distance !== want.avg ||
                   rsp_active_count !== want.active) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp st%0d sl%0d d%h a%h n%0d got st%0d sl%0d d%h a%h n%0d",
                        want.status, want.slot, want.dist_q8, want.avg, want.active,
                        rsp_status, rsp_slot, rsp_distance, rsp_average_distance,
                        rsp_active_count);
               end
            end
         end
         if (start && !busy) awaited.push_back(predict_sighting());
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr >> 2) == 3'(REG_DEFAULT_TX))
            first_seen_tx = csr_pwdata[7:0];
      end
   end
endmodule

@@ sim/testbench.sv @@
// stimulus and verdict for the beacon range tracking table
module testbench;
   import brt_pkg::*;

   localparam logic [2:0] CSR_DEFAULT_TX_ADDR = 3'd0;
   localparam logic [2:0] CSR_SPARE_ADDR      = 3'd4;   // no register here
   localparam int         CYCLE_LIMIT         = 400000;
   localparam int         POOL_SIZE           = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [47:0] req_address = '0;
   logic [7:0]  req_tx_power = '0;
   logic [7:0]  req_rssi = '0;
   logic [63:0] req_adv_head = '0;
   logic [7:0]  req_adv_byte8 = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_slot;
   logic [23:0] rsp_distance;
   logic [23:0] rsp_average_distance;
   logic [5:0]  rsp_active_count;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          outstanding;
   int          cycles = 0;

   // beacon addresses reused across items so lookups hit and the table fills up
   logic [47:0] beacon_pool [POOL_SIZE];
   bit          no_gaps;

   always #2 clock = ~clock;

   beacon_range_tracking_table_top dut (.*);

   beacon_range_tracking_table_checker checker_i (.*);

   // timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // csr write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // only change the default tx power once the block has drained
   task automatic quiesce();
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
   endtask

   // present one item after a random gap (none while no_gaps is set) and hold it until taken
   task automatic send_item(input logic act, input logic [47:0] addr, input logic [7:0] tx,
                            input logic [7:0] rssi, input logic [63:0] head,
                            input logic [7:0] byte8);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      repeat (gap) @(negedge clock);
      req_action = act;
      req_address = addr;
      req_tx_power = tx;
      req_rssi = rssi;
      req_adv_head = head;
      req_adv_byte8 = byte8;
      start = 1'b1;
      // busy low at a falling edge stays low up to the next rising edge
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic logic [7:0] dbm();
      return 8'(-$signed($urandom_range(0, 128)));
   endfunction

   task automatic scan(input logic [47:0] addr, input logic [7:0] rssi);
      send_item(ACT_SCAN, addr, dbm(), rssi, PREFIX_HEAD, PREFIX_BYTE8);
   endtask

   // well-formed traffic mostly, with some malformed advertisements and stray addresses
   task automatic random_item(input int pool_used);
      logic [47:0] addr;
      logic [63:0] head;
      logic [7:0]  byte8;
      int          pick;
      addr = ($urandom_range(0, 24) == 0) ? {$urandom(), 16'($urandom())}
                                          : beacon_pool[$urandom_range(0, pool_used - 1)];
      head = PREFIX_HEAD;
      byte8 = PREFIX_BYTE8;
      pick = $urandom_range(0, 19);
      if (pick == 0) head = {$urandom(), $urandom()};
      else if (pick == 1) head[$urandom_range(0, 63)] ^= 1'b1;
      else if (pick == 2) byte8 = 8'($urandom());
      send_item(($urandom_range(0, 3) != 0) ? ACT_SCAN : ACT_REGISTER, addr, dbm(), dbm(),
                head, byte8);
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) beacon_pool[i] = {$urandom(), 16'($urandom())};
      no_gaps = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every status but full, saturation edges, ring wrap
      send_item(ACT_REGISTER, 48'h0, 8'h80, 8'h00, '0, '0);
      send_item(ACT_REGISTER, 48'hFFFF_FFFF_FFFF, 8'h00, 8'h80, '1, '1);
      send_item(ACT_REGISTER, 48'hFFFF_FFFF_FFFF, 8'h80, 8'h00, '0, '0);   // already present
      send_item(ACT_SCAN, 48'h0, 8'h00, 8'h00, PREFIX_HEAD, PREFIX_BYTE8);   // far below zero
      send_item(ACT_SCAN, 48'hFFFF_FFFF_FFFF, 8'h00, 8'h80, PREFIX_HEAD, PREFIX_BYTE8);
      send_item(ACT_SCAN, 48'h0, 8'h00, 8'h00, ~PREFIX_HEAD, PREFIX_BYTE8);  // not a beacon
      send_item(ACT_SCAN, 48'h0, 8'h00, 8'h00, PREFIX_HEAD, ~PREFIX_BYTE8);
      send_item(ACT_REGISTER, beacon_pool[0], 8'hC4, 8'h00, '0, '0);
      // tx -60: rssi values give d of -32, -159, -80, -81, 0
      send_item(ACT_SCAN, beacon_pool[0], 8'h00, 8'(-156 + 128 + 128 - 128), PREFIX_HEAD,
                PREFIX_BYTE8);
      scan(beacon_pool[0], 8'(-60 - 97));
      scan(beacon_pool[0], 8'(-60 + 80));
      scan(beacon_pool[0], 8'(-60 + 81));
      scan(beacon_pool[0], 8'(-60));
      scan(beacon_pool[0], 8'(-128));
      for (int i = 0; i < 6; i++) scan(beacon_pool[0], dbm());   // wraps the ring
      scan(beacon_pool[1], 8'(-60));   // first seen in a scan, reset default tx

      // phases with different default tx power; the pool grows past the table size
      for (int phase = 0; phase < 4; phase++) begin
         quiesce();
         case (phase)
            0: csr_write(CSR_DEFAULT_TX_ADDR, 32'hFFFF_FF80);
            1: csr_write(CSR_DEFAULT_TX_ADDR, 32'h0);
            2: begin
               csr_write(CSR_SPARE_ADDR, 32'h0000_0011);   // ignored
               csr_write(CSR_DEFAULT_TX_ADDR, 32'h0000_00DB);
            end
            default: csr_write(CSR_DEFAULT_TX_ADDR, 32'h0000_00C4);
         endcase
         for (int n = 0; n < 220; n++) begin
            if (n % 55 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            random_item(12 + 12 * phase);
         end
      end

      quiesce();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
